/* rtl/cfq_pkg.sv */
// cfq_pkg: shared sizes, codes and item types of the circular fifo queue
// used by cfq_ram and circular_fifo_queue_top; depends on nothing else

package cfq_pkg;

	// storage geometry
	localparam int DEPTH      = 16;
	localparam int DATA_WIDTH = 32;
	localparam int ADDR_W     = $clog2(DEPTH);
	localparam int CNT_W      = $clog2(DEPTH + 1);

	// field widths
	localparam int MODE_W   = 2;
	localparam int STATUS_W = 2;
	localparam int CAP_W    = 5;

	// capacity after reset
	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(DEPTH);

	// request codes
	localparam logic [MODE_W-1:0] MODE_ENQ     = 2'd0;
	localparam logic [MODE_W-1:0] MODE_DEQ     = 2'd1;
	localparam logic [MODE_W-1:0] MODE_INSPECT = 2'd2;

	// status codes
	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
	localparam logic [STATUS_W-1:0] ST_NULL  = 2'd3;

	// request item
	typedef struct packed {
		logic [MODE_W-1:0]     mode;
		logic [DATA_WIDTH-1:0] data_in;
	} cfq_in_t;

	// result item
	typedef struct packed {
		logic [STATUS_W-1:0]   status;
		logic [DATA_WIDTH-1:0] data_out;
		logic [DATA_WIDTH-1:0] front_word;
		logic [DATA_WIDTH-1:0] rear_word;
		logic [CNT_W-1:0]      count;
	} cfq_out_t;

	// entry memory access
	typedef struct packed {
		logic                  we;
		logic [ADDR_W-1:0]     waddr;
		logic [DATA_WIDTH-1:0] wdata;
		logic                  re;
		logic [ADDR_W-1:0]     raddr;
	} cfq_ram_req_t;

endpackage

/* rtl/cfq_ram.sv */
// cfq_ram: entry memory of the circular fifo queue, one write and one read port
// read data is registered; depends on cfq_pkg

module cfq_ram (
	input  logic                         clk,
	input  cfq_pkg::cfq_ram_req_t        ram_req,
	output logic [cfq_pkg::DATA_WIDTH-1:0] rdata
);
	import cfq_pkg::*;

	logic [DATA_WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (ram_req.we) begin
			mem[ram_req.waddr] <= ram_req.wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (ram_req.re) begin
			rdata <= mem[ram_req.raddr];
		end
	end

endmodule

/* rtl/circular_fifo_queue_top.sv */
// circular_fifo_queue_top: ring-buffer queue with a programmable capacity
// depends on cfq_pkg and cfq_ram

// Each request item enqueues a word, dequeues the oldest word or only inspects
// the queue, and gives exactly one result item with status, removed word, front
// and rear words and count. Enqueue, inspect, refused and emptying requests load
// the result register directly on acceptance; a dequeue that leaves words behind
// first passes through the read state, because the new front word is fetched from
// the entry memory, whose read port is registered. The result sits in an output
// register; a new request is taken once that register is empty or being taken in
// the same cycle while no front fetch runs. The capacity register may be written
// whenever the queue is idle; zero acts as one and values above 16 act as 16.
// Entries need no clearing after reset, so the block is ready at once.

module circular_fifo_queue_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_stall,
	input  cfq_pkg::cfq_in_t            req,
	output logic                        rsp_valid,
	input  logic                        rsp_stall,
	output cfq_pkg::cfq_out_t           rsp,
	input  logic                        cfg_we,
	input  logic [cfq_pkg::CAP_W-1:0]   cfg_data
);
	import cfq_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_READ = 2'b10
	} state_t;

	// next position, wrapping at the capacity in use
	function automatic logic [ADDR_W-1:0] adv(input logic [ADDR_W-1:0] pos,
		input logic [CNT_W-1:0] cap);
		logic [CNT_W-1:0] nxt;
		nxt = CNT_W'(pos) + CNT_W'(1);
		if (nxt >= cap) begin
			return '0;
		end
		return nxt[ADDR_W-1:0];
	endfunction

	state_t                state_q;
	logic [CAP_W-1:0]      cap_q;
	logic [ADDR_W-1:0]     head_q;
	logic [ADDR_W-1:0]     tail_q;
	logic [CNT_W-1:0]      count_q;
	logic [DATA_WIDTH-1:0] front_q;
	logic [DATA_WIDTH-1:0] rear_q;
	logic                  rsp_valid_q;
	cfq_out_t              rsp_q;

	logic [CNT_W-1:0]      cap_use;
	logic                  acc;
	logic                  rsp_free;
	logic [ADDR_W-1:0]     head_d;
	logic [ADDR_W-1:0]     tail_d;
	logic [CNT_W-1:0]      count_d;
	logic [DATA_WIDTH-1:0] front_d;
	logic [DATA_WIDTH-1:0] rear_d;
	logic [STATUS_W-1:0]   status_d;
	logic [DATA_WIDTH-1:0] removed_d;
	logic                  fetch_d;
	cfq_ram_req_t          ram_req;
	logic [DATA_WIDTH-1:0] ram_rdata;

	cfq_ram u_ram (
		.clk     (clk),
		.ram_req (ram_req),
		.rdata   (ram_rdata)
	);

	// capacity in use, clamped to 1..DEPTH
	always_comb begin
		if (cap_q == '0) begin
			cap_use = CNT_W'(1);
		end else if (CNT_W'(cap_q) > CNT_W'(DEPTH)) begin
			cap_use = CNT_W'(DEPTH);
		end else begin
			cap_use = CNT_W'(cap_q);
		end
	end

	// handshake
	assign rsp_free  = !rsp_valid_q || !rsp_stall;
	assign req_stall = (state_q != S_IDLE) || !rsp_free;
	assign acc       = req_valid && !req_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// request decode and queue update
	always_comb begin
		head_d        = head_q;
		tail_d        = tail_q;
		count_d       = count_q;
		front_d       = front_q;
		rear_d        = rear_q;
		status_d      = ST_OK;
		removed_d     = '0;
		fetch_d       = 1'b0;
		ram_req       = '0;
		ram_req.wdata = req.data_in;
		ram_req.waddr = tail_q;
		case (req.mode)
			MODE_ENQ: begin
				if (req.data_in == '0) begin
					status_d = ST_NULL;
				end else if (count_q >= cap_use) begin
					status_d = ST_FULL;
				end else begin
					ram_req.we = acc;
					tail_d     = adv(tail_q, cap_use);
					count_d    = count_q + CNT_W'(1);
					rear_d     = req.data_in;
					// new word is the front when queue was empty or tail met head
					if (count_q == '0 || tail_q == head_q) begin
						front_d = req.data_in;
					end
				end
			end
			MODE_DEQ: begin
				if (count_q == '0) begin
					status_d = ST_EMPTY;
				end else begin
					removed_d = front_q;
					count_d   = count_q - CNT_W'(1);
					if (count_q == CNT_W'(1)) begin
						// drained: both positions return to entry 0
						head_d  = '0;
						tail_d  = '0;
						front_d = '0;
						rear_d  = '0;
					end else begin
						head_d        = adv(head_q, cap_use);
						fetch_d       = 1'b1;
						ram_req.re    = acc;
						ram_req.raddr = adv(head_q, cap_use);
					end
				end
			end
			default: begin
				// inspect, also for the unused code
				if (count_q == '0) begin
					status_d = ST_EMPTY;
				end
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cap_q       <= CAP_RESET;
			head_q      <= '0;
			tail_q      <= '0;
			count_q     <= '0;
			front_q     <= '0;
			rear_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_data;
			end
			unique case (state_q)
				S_IDLE: begin
					if (acc) begin
						head_q      <= head_d;
						tail_q      <= tail_d;
						count_q     <= count_d;
						front_q     <= front_d;
						rear_q      <= rear_d;
						rsp_valid_q <= !fetch_d;
						if (fetch_d) begin
							state_q <= S_READ;
						end
					end else if (!rsp_stall) begin
						rsp_valid_q <= 1'b0;
					end
				end
				S_READ: begin
					front_q     <= ram_rdata;
					rsp_valid_q <= 1'b1;
					state_q     <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (acc) begin
			rsp_q.status     <= status_d;
			rsp_q.data_out   <= removed_d;
			rsp_q.front_word <= front_d;
			rsp_q.rear_word  <= rear_d;
			rsp_q.count      <= count_d;
		end else if (state_q == S_READ) begin
			rsp_q.front_word <= ram_rdata;
		end
	end

	// the read cycle only runs while the result register is empty
	a_read_rsp_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_READ) |-> !rsp_valid_q)
		else $error("front fetch while a result is pending");

	// the front fetch always ends in a result
	a_read_delivers: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_READ) |=> (rsp_valid_q && state_q == S_IDLE))
		else $error("front fetch did not produce a result");

	// every accepted item yields a result or a front fetch
	a_accept_result: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> (rsp_valid_q || state_q == S_READ))
		else $error("accepted item produced nothing");

	// an empty queue reports no front and no rear word
	a_empty_words: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && rsp_q.count == '0) |->
		(rsp_q.front_word == '0 && rsp_q.rear_word == '0))
		else $error("empty queue shows stored words");

endmodule

/* bench/circular_fifo_queue_checker.sv */
// circular_fifo_queue_checker: watches the request, result and capacity ports of
// circular_fifo_queue_top, keeps its own copy of the queue and compares every result
// depends on cfq_pkg
`timescale 1ns / 100ps

module circular_fifo_queue_checker (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      req_valid,
	input  logic                      req_stall,
	input  cfq_pkg::cfq_in_t          req,
	input  logic                      rsp_valid,
	input  logic                      rsp_stall,
	input  cfq_pkg::cfq_out_t         rsp,
	input  logic                      cfg_we,
	input  logic [cfq_pkg::CAP_W-1:0] cfg_data,
	output int                        pending,
	output int                        fail_count
);

	import cfq_pkg::*;

	// mirrored queue state
	logic [DATA_WIDTH-1:0] word_store [DEPTH];
	int                    head_pos;
	int                    tail_pos;
	int                    rear_pos;
	int                    fill;
	logic [CAP_W-1:0]      cap_reg;

	// results predicted but not yet taken
	cfq_out_t awaited_results [$];

	initial begin
		pending    = 0;
		fail_count = 0;
	end

	// capacity in use: zero acts as one, oversize acts as full depth
	function automatic int cap_limit();
		if (cap_reg == '0)
			return 1;
		if (int'(cap_reg) > DEPTH)
			return DEPTH;
		return int'(cap_reg);
	endfunction

	// ring position after p, wrapping at the capacity in use
	function automatic int next_pos(int p);
		int n;
		n = p + 1;
		if (n >= cap_limit() || n >= DEPTH)
			return 0;
		return n;
	endfunction

	// apply one request to the mirrored queue and form its result
	function automatic cfq_out_t apply_request(cfq_in_t r);
		cfq_out_t res;
		res = '0;
		res.status = ST_OK;
		case (r.mode)
			MODE_ENQ: begin
				if (r.data_in == '0) begin
					res.status = ST_NULL;
				end else if (fill >= cap_limit()) begin
					res.status = ST_FULL;
				end else begin
					word_store[tail_pos] = r.data_in;
					rear_pos = tail_pos;
					tail_pos = next_pos(tail_pos);
					fill++;
				end
			end
			MODE_DEQ: begin
				if (fill == 0) begin
					res.status = ST_EMPTY;
				end else begin
					res.data_out = word_store[head_pos];
					head_pos = next_pos(head_pos);
					fill--;
					// drained queue restarts at entry 0
					if (fill == 0) begin
						head_pos = 0;
						tail_pos = 0;
						rear_pos = 0;
					end
				end
			end
			// inspect, and the unused code acting as inspect
			default: begin
				if (fill == 0)
					res.status = ST_EMPTY;
			end
		endcase
		if (fill != 0) begin
			res.front_word = word_store[head_pos];
			res.rear_word  = word_store[rear_pos];
		end
		res.count = CNT_W'(fill);
		return res;
	endfunction

	// one field of a result against its prediction
	task automatic compare_field(input string name, input logic [DATA_WIDTH-1:0] want,
			input logic [DATA_WIDTH-1:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
			fail_count++;
		end
	endtask

	// track capacity writes, predict accepted requests, check taken results
	always @(posedge clk or negedge arst_n) begin : track
		cfq_out_t want;
		if (!arst_n) begin
			head_pos = 0;
			tail_pos = 0;
			rear_pos = 0;
			fill     = 0;
			cap_reg  = CAP_RESET;
			awaited_results.delete();
			pending <= 0;
		end else begin
			if (cfg_we)
				cap_reg = cfg_data;
			if (req_valid && !req_stall)
				awaited_results.push_back(apply_request(req));
			if (rsp_valid && !rsp_stall) begin
				if (awaited_results.size() == 0) begin
					$display("%0t: result item with none expected, expected none actual %h",
						$time, rsp);
					fail_count++;
				end else begin
					want = awaited_results.pop_front();
					compare_field("status", DATA_WIDTH'(want.status), DATA_WIDTH'(rsp.status));
					compare_field("data_out", want.data_out, rsp.data_out);
					compare_field("front_word", want.front_word, rsp.front_word);
					compare_field("rear_word", want.rear_word, rsp.rear_word);
					compare_field("count", DATA_WIDTH'(want.count), DATA_WIDTH'(rsp.count));
				end
			end
			pending <= awaited_results.size();
		end
	end

endmodule

/* bench/circular_fifo_queue_top_tb.sv */
// circular_fifo_queue_top_tb: drives requests, capacity writes and result stalls
// into circular_fifo_queue_top and gives the verdict
// depends on cfq_pkg, circular_fifo_queue_top and circular_fifo_queue_checker
`timescale 1ns / 100ps

module circular_fifo_queue_top_tb;

	import cfq_pkg::*;

	// request code the block treats as inspect
	localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

	localparam int IDLE_LIMIT   = 2000;
	localparam int SEG_ITEMS    = 133;
	localparam int SEGS_PER_PH  = 4;
	localparam int TAIL_CYCLES  = 5;

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              req_valid = 1'b0;
	logic              req_stall;
	cfq_in_t           req       = '0;
	logic              rsp_valid;
	logic              rsp_stall = 1'b0;
	cfq_out_t          rsp;
	logic              cfg_we    = 1'b0;
	logic [CAP_W-1:0]  cfg_data  = '0;

	int                pending;
	int                fail_count;
	int                send_idle_pct = 0;
	int                rcv_stall_pct = 0;
	int                idle_cycles   = 0;

	// capacity settings for the first ten segments of the random part; later ones are random
	logic [CAP_W-1:0]  cap_plan [12] = '{5'd1, 5'd0, 5'd31, 5'd2, 5'd17, 5'd16,
		5'd3, 5'd0, 5'd8, 5'd31, 5'd1, 5'd12};

	circular_fifo_queue_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data)
	);

	circular_fifo_queue_checker u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.req        (req),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.rsp        (rsp),
		.cfg_we     (cfg_we),
		.cfg_data   (cfg_data),
		.pending    (pending),
		.fail_count (fail_count)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// random result stalls
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rsp_stall <= 1'b0;
		else
			rsp_stall <= ($urandom_range(0, 99) < rcv_stall_pct);
	end

	// no-progress watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	// offer one item, with random gaps ahead of it, and wait until taken
	task automatic send_item(input logic [MODE_W-1:0] m, input logic [DATA_WIDTH-1:0] d);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			req_valid    <= 1'b0;
			req.mode     <= MODE_W'($urandom);
			req.data_in  <= $urandom;
			@(posedge clk);
		end
		req_valid   <= 1'b1;
		req.mode    <= m;
		req.data_in <= d;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
	endtask

	// stop offering and wait for every outstanding result
	task automatic wait_idle();
		req_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	// capacity write on an idle block
	task automatic write_capacity(input logic [CAP_W-1:0] v);
		wait_idle();
		repeat (3) @(posedge clk);
		cfg_we   <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		cfg_we   <= 1'b0;
	endtask

	// random word, zero and all-ones now and then
	function automatic logic [DATA_WIDTH-1:0] pick_word();
		int r;
		r = $urandom_range(0, 99);
		if (r < 5)
			return '0;
		if (r < 10)
			return '1;
		return $urandom;
	endfunction

	initial begin : stimulus
		logic [DATA_WIDTH-1:0] w;
		logic [CAP_W-1:0]      cap;
		int                    enq_pct;
		int                    r;
		int                    idx;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part at reset capacity, sender idles lightly, receiver heavily
		send_idle_pct = 25;
		rcv_stall_pct = 72;
		send_item(MODE_ENQ, '0);
		send_item(MODE_DEQ, $urandom);
		send_item(MODE_INSPECT, $urandom);
		send_item(MODE_UNUSED, $urandom);
		send_item(MODE_ENQ, 32'hFFFF_FFFF);
		send_item(MODE_ENQ, 32'h0000_0001);
		send_item(MODE_ENQ, 32'h8000_0000);
		send_item(MODE_ENQ, 32'h7FFF_FFFF);
		// fill every entry once, so later capacity moves never read stale ones
		repeat (DEPTH - 4) begin
			w = $urandom;
			if (w == '0)
				w = 1;
			send_item(MODE_ENQ, w);
		end
		send_item(MODE_ENQ, 32'h1234_5678);
		send_item(MODE_ENQ, '0);
		send_item(MODE_INSPECT, $urandom);
		send_item(MODE_UNUSED, $urandom);
		send_item(MODE_DEQ, $urandom);

		// random part: three idling phases, capacity changes between segments
		for (int ph = 0; ph < 3; ph++) begin
			case (ph)
				0: begin
					send_idle_pct = 25;
					rcv_stall_pct = 72;
				end
				1: begin
					send_idle_pct = 72;
					rcv_stall_pct = 25;
				end
				default: begin
					send_idle_pct = 0;
					rcv_stall_pct = 0;
				end
			endcase
			for (int seg = 0; seg < SEGS_PER_PH; seg++) begin
				idx = ph * SEGS_PER_PH + seg;
				cap = (idx >= 10) ? CAP_W'($urandom_range(0, 31)) : cap_plan[idx];
				write_capacity(cap);
				enq_pct = $urandom_range(25, 75);
				repeat (SEG_ITEMS) begin
					r = $urandom_range(0, 99);
					if (r < enq_pct) begin
						send_item(MODE_ENQ, pick_word());
					end else begin
						r = $urandom_range(0, 99);
						if (r < 80)
							send_item(MODE_DEQ, $urandom);
						else if (r < 95)
							send_item(MODE_INSPECT, $urandom);
						else
							send_item(MODE_UNUSED, $urandom);
					end
				end
			end
		end

		// drain and give the verdict
		wait_idle();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

/* sim.f */
rtl/cfq_pkg.sv
rtl/cfq_ram.sv
rtl/circular_fifo_queue_top.sv
bench/circular_fifo_queue_checker.sv
bench/circular_fifo_queue_top_tb.sv
